/* hw/rtl/kbi_pkg.sv */
`timescale 1ns / 1ps

package kbi_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int FRAC_W       = FRAC_BITS + 1;
  localparam int TW           = FRAC_BITS + 3;
  localparam int FRAC_ONE     = 1 << FRAC_BITS;
  localparam int FRAC_HALF    = 1 << (FRAC_BITS - 1);
  localparam int WORDS        = 12;
  localparam int LIGHT_WORD   = 9;
  localparam int KIND_MIN     = 5;
  localparam int KIND_ALL_LIT = 8;
  localparam int KIND_RESET   = 5;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_LERP  = 1'b1;

  localparam logic CFG_OBJECT_KIND = 1'b0;
  localparam logic CFG_BAND_PHASE  = 1'b1;

  localparam logic [3:0] UC_PRV    = 4'd0;
  localparam logic [3:0] UC_REJECT = 4'd13;

  typedef struct packed {
    logic                     func;
    logic [3:0]               band;
    logic [3:0]               word_index;
    logic signed [31:0]       word_value;
    logic [FRAC_W-1:0]        fraction;
  } req_t;

  typedef struct packed {
    logic [3:0]         channel;
    logic signed [31:0] value;
    logic               accepted;
    logic               last;
  } rsp_t;

  // One step of the interpolation program.
  typedef struct packed {
    logic       rd_prv;
    logic       issue;
    logic       reject;
    logic       last;
    logic       done;
    logic [3:0] word;
  } ucode_t;

  function automatic ucode_t uc_rom(input logic [3:0] pc);
    ucode_t uc;
    uc = '0;
    case (pc)
      4'd0: begin
        uc.rd_prv = 1'b1;
        uc.word   = 4'(LIGHT_WORD);
      end
      4'd1:  begin uc.issue = 1'b1; uc.word = 4'd0;  end
      4'd2:  begin uc.issue = 1'b1; uc.word = 4'd1;  end
      4'd3:  begin uc.issue = 1'b1; uc.word = 4'd2;  end
      4'd4:  begin uc.issue = 1'b1; uc.word = 4'd3;  end
      4'd5:  begin uc.issue = 1'b1; uc.word = 4'd4;  end
      4'd6:  begin uc.issue = 1'b1; uc.word = 4'd5;  end
      4'd7:  begin uc.issue = 1'b1; uc.word = 4'd6;  end
      4'd8:  begin uc.issue = 1'b1; uc.word = 4'd7;  end
      4'd9:  begin uc.issue = 1'b1; uc.word = 4'd8;  end
      4'd10: begin uc.issue = 1'b1; uc.word = 4'd9;  end
      4'd11: begin uc.issue = 1'b1; uc.word = 4'd10; end
      4'd12: begin
        uc.issue = 1'b1;
        uc.word  = 4'd11;
        uc.last  = 1'b1;
        uc.done  = 1'b1;
      end
      4'd13: begin
        uc.issue  = 1'b1;
        uc.reject = 1'b1;
        uc.last   = 1'b1;
        uc.done   = 1'b1;
      end
      default: begin
        uc.done = 1'b1;
      end
    endcase
    return uc;
  endfunction

endpackage

/* hw/rtl/keyframe_band_interpolator_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_t: func, band, word, value, fraction
// rsp       out        rsp_valid / rsp_stall  rsp_t: channel, value, accepted, last
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// A store writes the table as it is taken. An interpolation runs a 13-step program
// (one read of the previous band's light word, then one channel per step through
// the shared multiplier) and drains a 3-stage datapath before a new request is taken.
// A rejected request takes one program step and the same drain.
// Reset is synchronous; the band table is not cleared and needs no clearing pass.
// A stalled result holds the whole program and datapath; a new request is
// taken as soon as the datapath is empty, even while the last beat still waits.

module keyframe_band_interpolator_core import kbi_pkg::*; #(
  parameter int BAND_COUNT = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  req_t          req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rsp_t          rsp,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [TW-1:0] cfg_data
);

  localparam int DEPTH = BAND_COUNT * WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(BAND_COUNT);
  localparam int DW    = 33;
  localparam int PW    = DW + TW;
  localparam int SW    = 37;

  localparam logic signed [TW:0]   T_ONE   = (TW+1)'(FRAC_ONE);
  localparam logic signed [TW-1:0] T_HALF  = TW'(FRAC_HALF);
  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sh8000_0000);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t  state;
  logic [3:0] pc;
  ucode_t  uc;

  logic [7:0]           object_kind;
  logic signed [TW-1:0] band_phase;
  logic                 all_lit;

  logic [BW-1:0]        cur;
  logic [BW-1:0]        nxt;
  logic [BW-1:0]        prv;
  logic signed [TW-1:0] t_val;

  logic [31:0] mem [DEPTH];
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] waddr;
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;

  ucode_t tag1;
  ucode_t tag2;
  ucode_t tag3;
  logic signed [31:0]   a2;
  logic signed [31:0]   b2;
  logic signed [DW-1:0] diff2;
  logic signed [31:0]   a3;
  logic signed [31:0]   b3;
  logic signed [PW-1:0] prod3;
  logic                 lit_p;

  logic adv;
  logic req_take;
  logic req_bad;
  logic [BW-1:0] band_in;
  logic [BW-1:0] band_up;
  logic [BW-1:0] band_dn;
  logic signed [TW:0] t_sum;

  logic signed [PW-1:0] shifted;
  logic signed [SW-1:0] sum;
  logic signed [31:0]   lerp_val;
  logic signed [31:0]   value_next;
  logic                 lit_c;
  logic                 lit_n;

  assign adv      = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || tag1.issue || tag2.issue || tag3.issue;
  assign req_take = req_valid && !req_stall;
  assign all_lit  = (object_kind == 8'(KIND_ALL_LIT));
  assign uc       = uc_rom(pc);

  // Request checks and the one-band phase step, done as the request is taken.
  always_comb begin
    req_bad = ({1'b0, req.band} >= 5'(BAND_COUNT)) ||
              (req.fraction > FRAC_W'(FRAC_ONE)) ||
              (object_kind < 8'(KIND_MIN));
    band_in = req.band[BW-1:0];
    band_up = (band_in == BW'(BAND_COUNT - 1)) ? '0 : band_in + 1'b1;
    band_dn = (band_in == '0) ? BW'(BAND_COUNT - 1) : band_in - 1'b1;
    t_sum   = $signed({{(TW-FRAC_BITS){1'b0}}, req.fraction}) +
              $signed({band_phase[TW-1], band_phase});
  end

  always_comb begin
    nxt    = (cur == BW'(BAND_COUNT - 1)) ? '0 : cur + 1'b1;
    prv    = (cur == '0) ? BW'(BAND_COUNT - 1) : cur - 1'b1;
    addr_a = uc.rd_prv ? AW'(prv) * AW'(WORDS) + AW'(LIGHT_WORD)
                       : AW'(cur) * AW'(WORDS) + AW'(uc.word);
    addr_b = AW'(nxt) * AW'(WORDS) + AW'(uc.word);
    waddr  = AW'(req.band) * AW'(WORDS) + AW'(req.word_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_kind <= 8'(KIND_RESET);
      band_phase  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBJECT_KIND: object_kind <= cfg_data[7:0];
        CFG_BAND_PHASE:  band_phase  <= $signed(cfg_data);
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && req.func == FUNC_STORE &&
        ({1'b0, req.band} < 5'(BAND_COUNT)) && (req.word_index < 4'(WORDS))) begin
      mem[waddr] <= req.word_value;
    end
    if (adv) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // Sequencer: the entry point is a conditional jump, valid requests start at
  // the previous-band read and rejected ones go straight to the reject step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= UC_PRV;
      tag1  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (adv) begin
            tag1 <= '0;
          end
          if (req_take && req.func == FUNC_LERP) begin
            state <= ST_RUN;
            pc    <= req_bad ? UC_REJECT : UC_PRV;
          end
        end
        ST_RUN: begin
          if (adv) begin
            tag1 <= uc;
            pc   <= pc + 1'b1;
            if (uc.done) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && req.func == FUNC_LERP && !req_bad) begin
      if (t_sum > T_ONE) begin
        cur   <= band_up;
        t_val <= TW'(t_sum - T_ONE);
      end else if (t_sum < -T_ONE) begin
        cur   <= band_dn;
        t_val <= TW'(t_sum + T_ONE);
      end else begin
        cur   <= band_in;
        t_val <= TW'(t_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
      tag3 <= '0;
    end else if (adv) begin
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tag1.rd_prv) begin
        lit_p <= (rd_a != '0) || all_lit;
      end
      a2    <= rd_a;
      b2    <= rd_b;
      diff2 <= DW'(rd_b) - DW'(rd_a);
      a3    <= a2;
      b3    <= b2;
      prod3 <= diff2 * t_val;
    end
  end

  always_comb begin
    shifted  = prod3 >>> FRAC_BITS;
    sum      = SW'(a3) + shifted[SW-1:0];
    if (sum > SAT_MAX) begin
      lerp_val = 32'sh7FFF_FFFF;
    end else if (sum < SAT_MIN) begin
      lerp_val = 32'sh8000_0000;
    end else begin
      lerp_val = sum[31:0];
    end
    lit_c = (a3 != '0) || all_lit;
    lit_n = (b3 != '0) || all_lit;
    if (tag3.reject) begin
      value_next = '0;
    end else if (tag3.word == 4'(LIGHT_WORD) && !(lit_p && lit_c && lit_n)) begin
      if (lit_c && t_val < T_HALF) begin
        value_next = a3;
      end else if (lit_n && t_val >= T_HALF) begin
        value_next = b3;
      end else begin
        value_next = '0;
      end
    end else begin
      value_next = lerp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= tag3.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag3.issue) begin
      rsp.channel  <= tag3.reject ? 4'd0 : tag3.word;
      rsp.value    <= value_next;
      rsp.accepted <= !tag3.reject;
      rsp.last     <= tag3.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> req_stall)
    else $error("request taken while the program runs");

  assert property (@(posedge clk) disable iff (rst)
    (req_take && req.func == FUNC_LERP) |=> (state == ST_RUN))
    else $error("interpolation request did not start the program");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.accepted) |-> (rsp.last && rsp.value == '0 && rsp.channel == 4'd0))
    else $error("malformed reject beat");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.accepted && rsp.last) |-> (rsp.channel == 4'(WORDS - 1)))
    else $error("last beat on a channel other than the final one");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({tag1.issue, tag1.rd_prv}))
    else $error("program step both reads the previous band and issues");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import kbi_pkg::*;

  localparam int BANDS       = 7;
  localparam int CYCLE_LIMIT = 200000;
  // Cycles allowed for the datapath to drain after the last awaited beat.
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASE_SPAN  = 1 << (FRAC_BITS + 1);
  localparam longint VALUE_MAX = 64'sh7FFF_FFFF;
  localparam longint VALUE_MIN = -64'sh8000_0000;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  req_t          req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  rsp_t          rsp;
  logic          cfg_we    = 1'b0;
  logic          cfg_index = CFG_OBJECT_KIND;
  logic [TW-1:0] cfg_data  = '0;

  // Shadow copy of the band table and the two registers.
  logic signed [31:0]   band_words [BANDS][WORDS];
  logic [7:0]           kind_reg;
  logic signed [TW-1:0] phase_reg;

  rsp_t awaited_beats [$];
  rsp_t want;
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;
  int   mismatches    = 0;
  int   beats_seen    = 0;
  int   lerps_sent    = 0;
  int   rejects_sent  = 0;
  int   stores_sent   = 0;
  int   cycle_count   = 0;

  keyframe_band_interpolator_core #(.BAND_COUNT(BANDS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99, 0) < rsp_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input longint t);
    longint sum;
    sum = longint'(a) + (((longint'(b) - longint'(a)) * t) >>> FRAC_BITS);
    if (sum > VALUE_MAX) sum = VALUE_MAX;
    if (sum < VALUE_MIN) sum = VALUE_MIN;
    return 32'(sum);
  endfunction

  function automatic logic band_lit(input int band);
    return (kind_reg == KIND_ALL_LIT) || (band_words[band][LIGHT_WORD] != 0);
  endfunction

  task automatic forecast_beats(input req_t item);
    longint             t;
    int                 cur;
    int                 nxt;
    int                 prv;
    logic signed [31:0] a;
    logic signed [31:0] b;
    rsp_t               beat;
    if (item.band >= BANDS || item.fraction > FRAC_ONE || kind_reg < KIND_MIN) begin
      beat = '{channel: '0, value: '0, accepted: 1'b0, last: 1'b1};
      awaited_beats.push_back(beat);
      rejects_sent++;
    end else begin
      t = longint'(item.fraction) + longint'(phase_reg);
      cur = int'(item.band);
      if (t > FRAC_ONE) begin
        cur = (cur + 1) % BANDS;
        t -= FRAC_ONE;
      end else if (t < -FRAC_ONE) begin
        cur = (cur + BANDS - 1) % BANDS;
        t += FRAC_ONE;
      end
      nxt = (cur + 1) % BANDS;
      prv = (cur + BANDS - 1) % BANDS;
      for (int ch = 0; ch < WORDS; ch++) begin
        a = band_words[cur][ch];
        b = band_words[nxt][ch];
        beat.channel  = 4'(ch);
        beat.accepted = 1'b1;
        beat.last     = (ch == WORDS - 1);
        // The light word only blends when all three neighbors are lit.
        if (ch == LIGHT_WORD && !(band_lit(prv) && band_lit(cur) && band_lit(nxt))) begin
          if (band_lit(cur) && t < FRAC_HALF) beat.value = a;
          else if (band_lit(nxt) && t >= FRAC_HALF) beat.value = b;
          else beat.value = '0;
        end else begin
          beat.value = blend(a, b, t);
        end
        awaited_beats.push_back(beat);
      end
      lerps_sent++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      beats_seen++;
      if (awaited_beats.size() == 0) begin
        $error("result beat with nothing awaited: channel %0d, value 0x%0h",
               rsp.channel, rsp.value);
        mismatches++;
      end else begin
        want = awaited_beats.pop_front();
        check_field("channel", 32'(want.channel), 32'(rsp.channel));
        check_field("value", want.value, rsp.value);
        check_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
        check_field("last", 32'(want.last), 32'(rsp.last));
      end
    end
  end

  // Within a run of items, valid is only lowered during idle cycles, so back-to-back items keep it high.
  task automatic send_item(input req_t item);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (item.func == FUNC_STORE) begin
      stores_sent++;
      if (item.band < BANDS && item.word_index < WORDS) begin
        band_words[item.band][item.word_index] = item.word_value;
      end
    end else begin
      forecast_beats(item);
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] kind, input int phase);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OBJECT_KIND;
    cfg_data  <= TW'(kind);
    @(posedge clk);
    cfg_index <= CFG_BAND_PHASE;
    cfg_data  <= TW'(phase);
    @(posedge clk);
    cfg_we    <= 1'b0;
    kind_reg  = kind;
    phase_reg = TW'(phase);
  endtask

  function automatic req_t lerp_item(input int band, input int frac);
    req_t item;
    item.func       = FUNC_LERP;
    item.band       = 4'(band);
    item.word_index = 4'($urandom_range(15, 0));
    item.word_value = $urandom();
    item.fraction   = FRAC_W'(frac);
    return item;
  endfunction

  function automatic req_t store_item(input int band, input int word,
                                      input logic [31:0] word_value);
    req_t item;
    item.func       = FUNC_STORE;
    item.band       = 4'(band);
    item.word_index = 4'(word);
    item.word_value = word_value;
    item.fraction   = FRAC_W'($urandom());
    return item;
  endfunction

  function automatic req_t random_item();
    req_t item;
    int   pick;
    int   frac_pick;
    frac_pick = $urandom_range(7, 0);
    case (frac_pick)
      0: item = lerp_item($urandom_range(BANDS - 1, 0), 0);
      1: item = lerp_item($urandom_range(BANDS - 1, 0), FRAC_ONE);
      2: item = lerp_item($urandom_range(BANDS - 1, 0),
                          $urandom_range(FRAC_HALF + 2, FRAC_HALF - 2));
      default: item = lerp_item($urandom_range(BANDS - 1, 0), $urandom_range(FRAC_ONE, 0));
    endcase
    pick = $urandom_range(99, 0);
    if (pick < 22) begin
      item = store_item(item.band, $urandom_range(WORDS - 1, 0), $urandom());
      if (item.word_index == LIGHT_WORD && $urandom_range(1, 0)) item.word_value = '0;
    end else if (pick < 27) begin
      // Store to an address outside the table.
      item = store_item(item.band, $urandom_range(15, 0), $urandom());
      if ($urandom_range(1, 0)) item.band = 4'($urandom_range(15, BANDS));
      else item.word_index = 4'($urandom_range(15, WORDS));
    end else if (pick < 33) begin
      if ($urandom_range(1, 0)) item.band = 4'($urandom_range(15, BANDS));
      else item.fraction = FRAC_W'($urandom_range((1 << FRAC_W) - 1, FRAC_ONE + 1));
    end
    return item;
  endfunction

  task automatic reset_block();
    repeat (12) @(posedge clk);
    rst       <= 1'b0;
    kind_reg  = 8'(KIND_RESET);
    phase_reg = '0;
  endtask

  // Bands 1 and 3 start unlit so the light word sees mixed neighbors.
  task automatic load_band_table();
    logic [31:0] word_value;
    for (int band = 0; band < BANDS; band++) begin
      for (int w = 0; w < WORDS; w++) begin
        word_value = $urandom();
        if (w == LIGHT_WORD) begin
          if (band == 1 || band == 3) word_value = '0;
          else word_value[0] = 1'b1;
        end
        send_item(store_item(band, w, word_value));
      end
    end
  endtask

  task automatic test_fraction_limits();
    send_item(lerp_item(0, 0));
    send_item(lerp_item(BANDS - 1, FRAC_ONE));
    send_item(lerp_item(BANDS, 0));
    send_item(lerp_item(15, (1 << FRAC_W) - 1));
    send_item(lerp_item(2, FRAC_ONE + 1));
  endtask

  task automatic test_store_addressing();
    send_item(store_item(BANDS, 0, 32'h7FFF_FFFF));
    send_item(store_item(15, 15, 32'h8000_0000));
    send_item(store_item(2, WORDS, 32'hFFFF_FFFF));
    send_item(store_item(4, 15, 32'h5555_AAAA));
    send_item(store_item(0, 0, 32'h8000_0000));
    send_item(store_item(1, 0, 32'h7FFF_FFFF));
    send_item(lerp_item(0, FRAC_ONE));
    send_item(lerp_item(2, FRAC_HALF));
  endtask

  task automatic test_phase_steps();
    settle();
    apply_settings(8'(KIND_RESET), PHASE_SPAN);
    // Steps to band 0 and still leaves t at 2.0, so channel 0 saturates high.
    send_item(lerp_item(BANDS - 1, FRAC_ONE));
    send_item(lerp_item(BANDS - 1, 0));
    settle();
    apply_settings(8'(KIND_RESET), -PHASE_SPAN);
    send_item(lerp_item(0, FRAC_ONE));
    send_item(lerp_item(0, 0));
  endtask

  task automatic test_object_kind();
    settle();
    apply_settings(8'(KIND_MIN - 1), 0);
    send_item(lerp_item(3, 100));
    settle();
    apply_settings(8'd0, 0);
    send_item(lerp_item(3, 100));
    settle();
    apply_settings(8'(KIND_ALL_LIT), 0);
    send_item(lerp_item(3, 100));
    send_item(lerp_item(2, 50000));
    settle();
    apply_settings(8'd255, 0);
    send_item(lerp_item(3, 40000));
  endtask

  task automatic test_light_channel();
    settle();
    apply_settings(8'(KIND_RESET), 0);
    send_item(lerp_item(2, 100));
    send_item(lerp_item(2, FRAC_HALF));
    send_item(lerp_item(3, FRAC_HALF));
    send_item(lerp_item(3, FRAC_HALF - 1));
    send_item(lerp_item(5, 30000));
  endtask

  task automatic test_random_traffic();
    int idle_modes [4]  = '{0, 55, 0, 17};
    int stall_modes [4] = '{0, 0, 55, 17};
    int kind_pick;
    int phase_pick;
    int kind;
    int phase;
    for (int mode = 0; mode < 4; mode++) begin
      for (int part = 0; part < 2; part++) begin
        settle();
        kind_pick  = $urandom_range(7, 0);
        phase_pick = $urandom_range(5, 0);
        case (kind_pick)
          0: kind = KIND_ALL_LIT;
          1: kind = 255;
          2: kind = KIND_MIN;
          default: kind = $urandom_range(255, KIND_MIN);
        endcase
        case (phase_pick)
          0: phase = -PHASE_SPAN;
          1: phase = PHASE_SPAN;
          2: phase = 0;
          default: phase = int'($urandom_range(2 * PHASE_SPAN, 0)) - PHASE_SPAN;
        endcase
        apply_settings(8'(kind), phase);
        send_idle_pct = idle_modes[mode];
        rsp_stall_pct = stall_modes[mode];
        repeat (2) send_item(random_item());
      end
    end
  endtask

  initial begin
    reset_block();
    load_band_table();
    test_fraction_limits();
    test_store_addressing();
    test_phase_steps();
    test_object_kind();
    test_light_channel();
    test_random_traffic();
    settle();
    $display("Covered %0d interpolations, %0d rejected requests and %0d table stores",
             lerps_sent, rejects_sent, stores_sent);
    $display("including 8 random register settings; %0d result beats checked.", beats_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/kbi_pkg.sv
hw/rtl/keyframe_band_interpolator_core.sv
bench/tb.sv
